// ----- sv/emg_rectify_lowpass_window_sum_macros.svh -----
// Assertion macros shared by the envelope block.
`ifndef EMG_RECTIFY_LOWPASS_WINDOW_SUM_MACROS_SVH
`define EMG_RECTIFY_LOWPASS_WINDOW_SUM_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ELWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ELWS_NEVER(label, cond, msg) \
  `ELWS_ASSERT(label, !(cond), msg)

`endif

// ----- sv/elws_pkg.sv -----
// Package with widths, register codes and shared types of the envelope block.
package elws_pkg;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned LevelW  = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SumW    = 42;
  localparam int unsigned CountW  = 10;
  localparam int unsigned ValueW  = 20;
  localparam int unsigned OutShift = 32;

  localparam int unsigned MaxWindowSamples = 1023;

  // Scaling multiply is split into two halves of the sum.
  localparam int unsigned HalfW   = SumW / 2;
  localparam int unsigned ProdW   = HalfW + CoefW;
  localparam int unsigned FullW   = SumW + CoefW;
  localparam int unsigned ScaledW = FullW - OutShift;

  // Result queue; depth must be a power of two so the pointers wrap.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned CreditW   = $clog2(FifoDepth + 1);

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CoefW-1:0] AlphaReset  = 16'd1489;
  localparam logic [CodeW-1:0] OffsetReset = 16'd8126;
  localparam logic [CoefW-1:0] GainReset   = 16'd960;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [ValueW-1:0] ValueMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlpha  = 2'd0,
    CfgOffset = 2'd1,
    CfgGain   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [CoefW-1:0] alpha;
    logic [CodeW-1:0] offset;
    logic [CoefW-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } tick_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
  } result_t;

endpackage

// ----- sv/elws_filter.sv -----
// Rectifier, one-pole low-pass and window accumulator of the envelope block.
module elws_filter import elws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  opcode_e          in_op_i,
  input  logic [CodeW-1:0] in_code_i,
  output tick_t            tick_o
);

  logic [CodeW-1:0] rect_d;

  logic             s0_valid_q;
  opcode_e          s0_op_q;
  logic [CodeW-1:0] s0_x_q;

  logic             s1_valid_q;
  opcode_e          s1_op_q;

  logic [LevelW-1:0] level_q, level_d;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;

  logic              tick_valid_q;
  logic [SumW-1:0]   tick_sum_q;
  logic [CountW-1:0] tick_count_q;

  logic signed [LevelW:0]             diff;
  logic signed [LevelW+CoefW+1:0]     prod;
  logic [LevelW+CoefW+1-FracW:0]      step;
  logic [SumW:0]                      sum_ext;
  logic [SumW-1:0]                    sum_sat;
  logic                               room;

  // Full-wave rectify about the baseline.
  assign rect_d = (in_code_i >= cfg_i.offset) ? (in_code_i - cfg_i.offset)
                                              : (cfg_i.offset - in_code_i);

  // level += floor(alpha * ((x << 16) - level) / 2^16)
  assign diff    = $signed({1'b0, s0_x_q, {FracW{1'b0}}}) - $signed({1'b0, level_q});
  assign prod    = $signed({1'b0, cfg_i.alpha}) * diff;
  assign step    = prod[LevelW+CoefW+1:FracW];
  assign level_d = level_q + step[LevelW-1:0];

  assign sum_ext = {1'b0, sum_q} + {{(SumW+1-LevelW){1'b0}}, level_q};
  assign sum_sat = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
  assign room    = count_q < CountW'(MaxWindowSamples);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      s0_op_q      <= OpSample;
      s1_valid_q   <= 1'b0;
      s1_op_q      <= OpSample;
      level_q      <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      tick_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_valid_i;
      s0_op_q    <= in_op_i;
      s1_valid_q <= s0_valid_q;
      s1_op_q    <= s0_op_q;

      if (s0_valid_q && s0_op_q == OpSample) begin
        level_q <= level_d;
      end

      // The sum stage sees the level written by its own item in the stage before.
      tick_valid_q <= 1'b0;
      if (s1_valid_q) begin
        unique case (s1_op_q)
          OpSample: begin
            if (room) begin
              sum_q   <= sum_sat;
              count_q <= count_q + 1'b1;
            end
          end
          OpTick: begin
            tick_valid_q <= 1'b1;
            sum_q        <= '0;
            count_q      <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    s0_x_q <= rect_d;
    if (s1_valid_q && s1_op_q == OpTick) begin
      tick_sum_q   <= sum_q;
      tick_count_q <= count_q;
    end
  end

  assign tick_o.valid = tick_valid_q;
  assign tick_o.sum   = tick_sum_q;
  assign tick_o.count = tick_count_q;

endmodule

// ----- sv/elws_scale.sv -----
// Two-stage gain multiply and saturation of a closed window sum.
module elws_scale import elws_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CoefW-1:0] gain_i,
  input  tick_t            tick_i,
  output result_t          result_o
);

  logic              p_valid_q;
  logic [ProdW-1:0]  p_lo_q, p_hi_q;
  logic [CountW-1:0] p_count_q;

  logic              r_valid_q;
  logic [ValueW-1:0] r_value_q;
  logic [CountW-1:0] r_count_q;

  logic [FullW-1:0]   total;
  logic [ScaledW-1:0] scaled;
  logic [ValueW-1:0]  value_d;

  // Add the shifted upper partial product, drop the fraction, clamp.
  assign total   = {p_hi_q, {HalfW{1'b0}}} + FullW'(p_lo_q);
  assign scaled  = total[FullW-1:OutShift];
  assign value_d = (scaled > ScaledW'(ValueMax)) ? ValueMax : scaled[ValueW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      p_valid_q <= tick_i.valid;
      r_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_lo_q    <= ProdW'(tick_i.sum[HalfW-1:0]) * ProdW'(gain_i);
    p_hi_q    <= ProdW'(tick_i.sum[SumW-1:HalfW]) * ProdW'(gain_i);
    p_count_q <= tick_i.count;
    r_value_q <= value_d;
    r_count_q <= p_count_q;
  end

  assign result_o.valid = r_valid_q;
  assign result_o.value = r_value_q;
  assign result_o.count = r_count_q;

endmodule

// ----- sv/emg_rectify_lowpass_window_sum.sv -----
// Top level of the EMG envelope block: rectify, low-pass, window sum, scaled result.
// Throughput: one item per cycle; tready drops only while eight window results are owed.
// Path: a tick item's result passes the input register, filter stage, window capture, partial products,
// and sum and clamp, then waits in the queue.
// Reset (async, active low): level, sum, count and queue clear; registers take defaults.
`include "emg_rectify_lowpass_window_sum_macros.svh"

module emg_rectify_lowpass_window_sum import elws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [15:0] sample_code
  input  logic               s_axis_tuser,   // [0] opcode
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata    // [19:0] window_value, [29:20] window_samples
);

  cfg_t    cfg_q;
  tick_t   tick;
  result_t result;

  logic in_fire, out_fire, tick_fire;

  // Credits count tick items accepted and not yet delivered; they bound the queue.
  logic [CreditW-1:0] credits_q;

  logic [ValueW+CountW-1:0] fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CreditW-1:0]       fifo_cnt_q;

  assign s_axis_tready = credits_q < CreditW'(FifoDepth);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = in_fire && (opcode_e'(s_axis_tuser) == OpTick);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // Register file; writes to an unused index drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha  <= AlphaReset;
      cfg_q.offset <= OffsetReset;
      cfg_q.gain   <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgAlpha:  cfg_q.alpha  <= cfg_data_i;
        CfgOffset: cfg_q.offset <= cfg_data_i;
        CfgGain:   cfg_q.gain   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  elws_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_fire),
    .in_op_i    (opcode_e'(s_axis_tuser)),
    .in_code_i  (s_axis_tdata),
    .tick_o     (tick)
  );

  elws_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gain_i   (cfg_q.gain),
    .tick_i   (tick),
    .result_o (result)
  );

  // Credit counter: advance on an accepted tick, release on a delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credits_q <= '0;
    end else if (tick_fire && !out_fire) begin
      credits_q <= credits_q + 1'b1;
    end else if (!tick_fire && out_fire) begin
      credits_q <= credits_q - 1'b1;
    end
  end

  // Result queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (result.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (result.valid && !out_fire) begin
        fifo_cnt_q <= fifo_cnt_q + 1'b1;
      end else if (!result.valid && out_fire) begin
        fifo_cnt_q <= fifo_cnt_q - 1'b1;
      end
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      fifo_q[wr_ptr_q] <= {result.count, result.value};
    end
  end

  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = {{(32-ValueW-CountW){1'b0}}, fifo_q[rd_ptr_q]};

  `ELWS_ASSERT(credit_bound_a, credits_q <= CreditW'(FifoDepth), "credit count above queue depth")
  `ELWS_ASSERT(queue_within_credit_a, fifo_cnt_q <= credits_q, "queue holds more than owed")
  `ELWS_NEVER(push_into_full_a, result.valid && fifo_cnt_q == CreditW'(FifoDepth), "result pushed into full queue")

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the EMG envelope block: windowed rectify and low-pass sums.
`timescale 1ns / 100ps

module tb;
  import elws_pkg::*;

  // One closed window as the block should report it.
  typedef struct {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] samples;
  } window_t;

  // Bit-accurate envelope predictor plus the queue of windows still owed by the block.
  class window_envelope;
    logic [CoefW-1:0]  alpha;
    logic [CodeW-1:0]  offset;
    logic [CoefW-1:0]  gain;
    logic [LevelW-1:0] level;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    window_t           owed_windows[$];
    int                errors;

    function new();
      alpha  = AlphaReset;
      offset = OffsetReset;
      gain   = GainReset;
      level  = '0;
      sum    = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CfgAlpha:  alpha  = value;
        CfgOffset: offset = value;
        CfgGain:   gain   = value;
        default: ;
      endcase
    endfunction

    // Advance the envelope by one accepted item; a tick closes the window.
    function void absorb_item(opcode_e op, logic [CodeW-1:0] code);
      logic [CodeW-1:0]   rect;
      logic signed [63:0] diff;
      logic signed [63:0] prod;
      logic [SumW:0]      grown;
      logic [57:0]        scaled;
      window_t            win;
      if (op == OpSample) begin
        rect = (code >= offset) ? code - offset : offset - code;
        diff = $signed({32'h0, rect, 16'h0}) - $signed({32'h0, level});
        prod = $signed({48'h0, alpha}) * diff;
        // floor(prod / 2^16), kept modulo 2^32
        level = level + prod[47:16];
        if (count < MaxWindowSamples) begin
          grown = {1'b0, sum} + level;
          sum   = (grown > SumMax) ? SumMax : grown[SumW-1:0];
          count = count + 1'b1;
        end
      end else begin
        scaled      = 58'(sum) * 58'(gain);
        win.value   = (scaled[57:32] > ValueMax) ? ValueMax : scaled[51:32];
        win.samples = count;
        owed_windows.insert(owed_windows.size(), win);
        sum   = '0;
        count = '0;
      end
    endfunction

    function void match_window(logic [ValueW-1:0] value, logic [CountW-1:0] samples);
      window_t win;
      if (owed_windows.size() == 0) begin
        errors++;
        $error("window result with none owed: window_value %0d window_samples %0d",
               value, samples);
        return;
      end
      win = owed_windows.pop_front();
      if (value !== win.value) begin
        errors++;
        $error("window_value: expected %0d, actual %0d", win.value, value);
      end
      if (samples !== win.samples) begin
        errors++;
        $error("window_samples: expected %0d, actual %0d", win.samples, samples);
      end
    endfunction

    function int pending();
      return owed_windows.size();
    endfunction
  endclass

  localparam int QuietLimit = 4000;
  // Cycles to let the pipeline empty after the last owed window arrives.
  localparam int DrainCycles = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoefW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;   // [15:0] sample_code
  logic               s_axis_tuser = 1'b0; // [0] opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;        // [19:0] window_value, [29:20] window_samples

  window_envelope env = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  emg_rectify_lowpass_window_sum uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: stall at random, check every window result taken at a rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= !(sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      env.match_window(m_axis_tdata[19:0], m_axis_tdata[29:20]);
    end
  end

  // Watchdog: end the run once nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
      default: begin src_idle_pct = 16; sink_stall_pct = 16; end
    endcase
  endtask

  // Present one item; hold it until the block takes it, then feed the predictor.
  task automatic send_item(opcode_e op, logic [CodeW-1:0] code);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    env.absorb_item(op, code);
  endtask

  // Drop valid, wait for every owed window, then let trailing samples clear the pipeline.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (env.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only call while the block is idle.
  task automatic apply_setting(logic [15:0] alpha, logic [15:0] offset, logic [15:0] gain);
    cfg_idx_e         idx [3];
    logic [15:0]      val [3];
    idx = '{CfgAlpha, CfgOffset, CfgGain};
    val = '{alpha, offset, gain};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      env.set_reg(idx[i], val[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sample codes: rails, codes close to the baseline (both sides), or anything.
  function automatic logic [CodeW-1:0] random_code();
    int near;
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: begin
        near = int'(env.offset) + int'($urandom_range(0, 64)) - 32;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return 16'(near);
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Windows of random length closed by a tick; some windows stay empty.
  task automatic run_windows(int budget);
    int left;
    int len;
    left = budget;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < len && left > 1; i++) begin
        send_item(OpSample, random_code());
        left--;
      end
      send_item(OpTick, 16'($urandom_range(0, 65535)));
      left--;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: empty window first, then rails and codes around the baseline.
    set_idling(0);
    send_item(OpTick, 16'h0000);
    send_item(OpSample, 16'h0000);
    send_item(OpSample, 16'hFFFF);
    send_item(OpSample, OffsetReset);
    send_item(OpSample, OffsetReset - 16'd1);
    send_item(OpSample, OffsetReset + 16'd1);
    send_item(OpTick, 16'hFFFF);
    send_item(OpTick, 16'h0000);

    // Full-scale level with maximum gain saturates the window value; the drop to zero
    // exercises the negative filter step rounding toward minus infinity.
    settle();
    apply_setting(16'hFFFF, 16'h0000, 16'hFFFF);
    set_idling(3);
    repeat (17) send_item(OpSample, 16'hFFFF);
    send_item(OpSample, 16'h0000);
    send_item(OpTick, 16'h0000);

    // Random windows under every idling pattern and a spread of register settings.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: apply_setting(16'h0000, 16'hFFFF, 16'hFFFF);
        1: apply_setting(16'hFFFF, 16'h0000, 16'h0000);
        default: apply_setting(pick_reg(), pick_reg(), pick_reg());
      endcase
      set_idling(ph % 4);
      run_windows(103);
    end

    settle();
    if (env.errors == 0 && env.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
